/* src/button_debounce_click_detector_defines.svh */
// Assertion macros shared by the button debounce and click detector RTL.
`ifndef BUTTON_DEBOUNCE_CLICK_DETECTOR_DEFINES_SVH
`define BUTTON_DEBOUNCE_CLICK_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked only while the block is out of reset.
`define BDCD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bdcd assertion failed");

// Next-cycle implication, checked only while the block is out of reset.
`define BDCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bdcd assertion failed");

`endif

/* src/bdcd_pkg.sv */
// Package with register indexes, reset values and widths of the button detector.
package bdcd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CONF_W     = 4;
    localparam int CLICK_W    = 4;
    localparam int FIELD_TIME_W = 32;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    typedef logic [CONF_W-1:0]     t_conf;
    typedef logic [CLICK_W-1:0]    t_click;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_DEBOUNCE   = 3'd0;
    localparam t_cfg_idx CFG_CONFIRM    = 3'd1;
    localparam t_cfg_idx CFG_LONG       = 3'd2;
    localparam t_cfg_idx CFG_VERY_LONG  = 3'd3;
    localparam t_cfg_idx CFG_GAP        = 3'd4;
    localparam t_cfg_idx CFG_HOLD       = 3'd5;

    // Configuration reset values.
    localparam t_cfg_data DEBOUNCE_RST  = 16'd50;
    localparam t_conf     CONFIRM_RST   = 4'd3;
    localparam t_cfg_data LONG_RST      = 16'd1000;
    localparam t_cfg_data VERY_LONG_RST = 16'd3000;
    localparam t_cfg_data GAP_RST       = 16'd400;
    localparam t_cfg_data HOLD_RST      = 16'd5000;

    // The click counter stops here.
    localparam t_click CLICK_MAX = 4'd15;

endpackage

/* src/button_debounce_click_detector.sv */
// Button debounce, click counting and long-press detector, one sample per word.
// A word accepted into the input register moves to the result register when that is free.
// Throughput: one word per cycle while i_out_stall is low; an input register and a result register
// are parted, so a new word is taken while a finished result waits.
// Reset (i_rst_n low, synchronous): all detector state cleared, button seen
// as released, and every configuration register back to its default value.
`include "button_debounce_click_detector_defines.svh"

module button_debounce_click_detector #(
    parameter int TIME_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port.
    input  logic                       i_cfg_we,
    input  bdcd_pkg::t_cfg_idx         i_cfg_index,
    input  bdcd_pkg::t_cfg_data        i_cfg_data,
    // Sample channel.
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_raw_level,
    input  logic [31:0]                i_now_ms,
    input  logic                       i_clear_clicks,
    // Result channel.
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_pressed,
    output logic                       o_stable_pressed,
    output logic                       o_long_press_event,
    output logic                       o_very_long_press_event,
    output logic                       o_hold_event,
    output logic [31:0]                o_hold_duration,
    output logic                       o_series_end_event,
    output logic [3:0]                 o_series_clicks,
    output logic [3:0]                 o_click_total
);
    import bdcd_pkg::*;

    // Compare width: wide enough for a timestamp difference and twice the debounce time.
    localparam int CW = (TIME_BITS > CFG_DATA_W + 1) ? TIME_BITS : CFG_DATA_W + 1;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CW-1:0]        t_cmp;

    // Configuration registers.
    t_cfg_data r_debounce, r_long, r_very_long, r_gap, r_hold;
    t_conf     r_confirm;

    // Input register.
    logic  r_in_vld;
    logic  r_raw;
    t_time r_now;
    logic  r_clr;

    // Detector state.
    logic   r_last_raw, r_stable_level, r_press_active, r_long_rep, r_vlong_rep;
    t_time  r_raw_change_time, r_stable_since, r_press_start, r_last_click_time;
    t_conf  r_confirm_count;
    t_click r_click_count;

    logic   n_last_raw, n_stable_level, n_press_active, n_long_rep, n_vlong_rep;
    t_time  n_raw_change_time, n_stable_since, n_press_start, n_last_click_time;
    t_conf  n_confirm_count;
    t_click n_click_count;

    // Result values of the word in the input register.
    logic   n_long_ev, n_vlong_ev, n_hold_ev, n_series_ev, n_stable_pr;
    t_time  n_hold_dur;
    t_click n_series_n;

    logic advance;

    // The word in the input register moves on when the result register is free.
    assign advance    = r_in_vld && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DEBOUNCE_RST;
            r_confirm   <= CONFIRM_RST;
            r_long      <= LONG_RST;
            r_very_long <= VERY_LONG_RST;
            r_gap       <= GAP_RST;
            r_hold      <= HOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_data;
                CFG_CONFIRM:   r_confirm   <= i_cfg_data[CONF_W-1:0];
                CFG_LONG:      r_long      <= i_cfg_data;
                CFG_VERY_LONG: r_very_long <= i_cfg_data;
                CFG_GAP:       r_gap       <= i_cfg_data;
                CFG_HOLD:      r_hold      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: takes a word whenever its slot is empty or being emptied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_raw <= i_raw_level;
            r_now <= i_now_ms[TIME_BITS-1:0];
            r_clr <= i_clear_clicks;
        end
    end

    // One sample of debounce, press timing and click series logic.
    always_comb begin
        logic   raw_chg, past_db, accept, press_started, clicked;
        t_time  dur_old, dur_new, gap_el;
        t_cmp   twice_db;
        t_conf  conf0;

        n_last_raw        = r_last_raw;
        n_raw_change_time = r_raw_change_time;
        n_confirm_count   = r_confirm_count;
        n_stable_level    = r_stable_level;
        n_stable_since    = r_stable_since;
        n_press_active    = r_press_active;
        n_press_start     = r_press_start;
        n_long_rep        = r_long_rep;
        n_vlong_rep       = r_vlong_rep;
        n_click_count     = r_clr ? '0 : r_click_count;
        n_last_click_time = r_last_click_time;
        n_long_ev         = 1'b0;
        n_vlong_ev        = 1'b0;
        n_hold_ev         = 1'b0;
        n_hold_dur        = '0;
        n_series_ev       = 1'b0;
        n_series_n        = '0;
        press_started     = 1'b0;
        clicked           = 1'b0;

        twice_db = CW'({r_debounce, 1'b0});

        // A raw level change restarts the debounce timer.
        raw_chg = (r_raw != r_last_raw);
        conf0   = raw_chg ? '0 : r_confirm_count;
        if (raw_chg) begin
            n_last_raw        = r_raw;
            n_raw_change_time = r_now;
        end
        past_db = !raw_chg &&
                  (CW'(t_time'(r_now - r_raw_change_time)) > CW'(r_debounce));

        n_confirm_count = conf0;
        if (past_db && (conf0 < r_confirm)) begin
            n_confirm_count = CONF_W'(conf0 + 1'b1);
        end
        accept = past_db && (n_confirm_count >= r_confirm) && (r_raw != r_stable_level);

        // A new stable level starts or ends a press.
        dur_old = t_time'(r_now - r_press_start);
        if (accept) begin
            n_stable_level = r_raw;
            n_stable_since = r_now;
            if (!r_raw) begin
                if (!r_press_active) begin
                    press_started  = 1'b1;
                    n_press_active = 1'b1;
                    n_press_start  = r_now;
                    n_long_rep     = 1'b0;
                    n_vlong_rep    = 1'b0;
                end
            end else if (r_press_active) begin
                if (CW'(dur_old) > twice_db) begin
                    if (CW'(dur_old) < CW'(r_long)) begin
                        clicked = 1'b1;
                        if (n_click_count < CLICK_MAX) begin
                            n_click_count = CLICK_W'(n_click_count + 1'b1);
                        end
                        n_last_click_time = r_now;
                    end
                    if (CW'(dur_old) >= CW'(r_hold)) begin
                        n_hold_ev  = 1'b1;
                        n_hold_dur = dur_old;
                    end
                end
                n_press_active = 1'b0;
            end
        end

        // The series ends once the gap after the last click has run out.
        gap_el = clicked ? '0 : t_time'(r_now - r_last_click_time);
        if ((n_click_count != '0) && (CW'(gap_el) > CW'(r_gap))) begin
            n_series_ev   = 1'b1;
            n_series_n    = n_click_count;
            n_click_count = '0;
        end

        // Long and very-long events fire once per press.
        dur_new = press_started ? '0 : dur_old;
        if (n_press_active && !n_stable_level) begin
            if (!n_long_rep && (CW'(dur_new) >= CW'(r_long)) &&
                (CW'(dur_new) < CW'(r_very_long))) begin
                n_long_rep = 1'b1;
                n_long_ev  = 1'b1;
            end
            if (!n_vlong_rep && (CW'(dur_new) >= CW'(r_very_long))) begin
                n_vlong_rep = 1'b1;
                n_long_rep  = 1'b1;
                n_vlong_ev  = 1'b1;
            end
        end

        n_stable_pr = !n_stable_level && !accept &&
                      (CW'(t_time'(r_now - r_stable_since)) > twice_db);
    end

    // Detector state advances with each word that moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw        <= 1'b1;
            r_raw_change_time <= '0;
            r_confirm_count   <= '0;
            r_stable_level    <= 1'b1;
            r_stable_since    <= '0;
            r_press_active    <= 1'b0;
            r_press_start     <= '0;
            r_long_rep        <= 1'b0;
            r_vlong_rep       <= 1'b0;
            r_click_count     <= '0;
            r_last_click_time <= '0;
        end else if (advance) begin
            r_last_raw        <= n_last_raw;
            r_raw_change_time <= n_raw_change_time;
            r_confirm_count   <= n_confirm_count;
            r_stable_level    <= n_stable_level;
            r_stable_since    <= n_stable_since;
            r_press_active    <= n_press_active;
            r_press_start     <= n_press_start;
            r_long_rep        <= n_long_rep;
            r_vlong_rep       <= n_vlong_rep;
            r_click_count     <= n_click_count;
            r_last_click_time <= n_last_click_time;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (!o_out_valid || !i_out_stall) begin
            o_out_valid <= r_in_vld;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_pressed               <= !n_stable_level;
            o_stable_pressed        <= n_stable_pr;
            o_long_press_event      <= n_long_ev;
            o_very_long_press_event <= n_vlong_ev;
            o_hold_event            <= n_hold_ev;
            o_hold_duration         <= FIELD_TIME_W'(n_hold_dur);
            o_series_end_event      <= n_series_ev;
            o_series_clicks         <= n_series_n;
            o_click_total           <= n_click_count;
        end
    end

    // A finished series always leaves the counter empty.
    `BDCD_ASSERT_IMPL(a_series_clears, i_clk, i_rst_n, o_out_valid && o_series_end_event, o_click_total == '0)
    // Without a series end no count is reported.
    `BDCD_ASSERT_IMPL(a_series_n_zero, i_clk, i_rst_n, o_out_valid && !o_series_end_event, o_series_clicks == '0)
    // The long and very-long events never fire together.
    `BDCD_ASSERT_IMPL(a_one_long_ev, i_clk, i_rst_n, o_out_valid, !(o_long_press_event && o_very_long_press_event))
    // A buffered word reaches the result register when it is free.
    `BDCD_ASSERT_NEXT(a_word_moves, i_clk, i_rst_n, r_in_vld && !(o_out_valid && i_out_stall), o_out_valid)

endmodule
